>>> rtl/core/mit_command_frame_encoder_assert.svh
// Assertion macros for the command frame encoder.
// Expects clk and arst_n in the scope of each use.
`ifndef MIT_COMMAND_FRAME_ENCODER_ASSERT_SVH
`define MIT_COMMAND_FRAME_ENCODER_ASSERT_SVH

// same-cycle implication
`define MIT_CFE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MIT_CFE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/mit_cfe_pkg.sv
// Types and constants shared by the command frame encoder.
// No dependencies.
package mit_cfe_pkg;

	localparam int NUM_LANES = 5;
	localparam int LIMIT_W   = 31;
	localparam int QUO_W     = 16;
	localparam int POS_BITS  = 16;
	localparam int CODE_BITS = 12;
	localparam int DIV_STEPS = QUO_W;

	localparam int LANE_POS = 0;
	localparam int LANE_VEL = 1;
	localparam int LANE_KP  = 2;
	localparam int LANE_KD  = 3;
	localparam int LANE_TQ  = 4;

	// lanes quantized over a symmetric range, and the lane with the 16-bit code
	localparam logic [NUM_LANES-1:0] LANE_SYM  = 5'b10011;
	localparam logic [NUM_LANES-1:0] LANE_WIDE = 5'b00001;

	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_POSITION  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_VELOCITY  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_TORQUE    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_STIFFNESS = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_DAMPING   = 3'd4;

	typedef logic [LIMIT_W-1:0] mit_cfe_limit_t;
	typedef mit_cfe_limit_t [NUM_LANES-1:0] mit_cfe_limits_t;

	localparam mit_cfe_limits_t LIMIT_RESET = {
		31'd655360,    // torque
		31'd327680,    // damping
		31'd32768000,  // stiffness
		31'd1966080,   // velocity
		31'd819200     // position
	};

	typedef struct packed {
		logic        [10:0] target_id;
		logic signed [31:0] cmd_position;
		logic signed [31:0] cmd_velocity;
		logic signed [31:0] gain_stiff;
		logic signed [31:0] gain_damp;
		logic signed [31:0] cmd_torque;
	} mit_cfe_cmd_t;

	typedef struct packed {
		logic [10:0] frame_id;
		logic [63:0] payload;
	} mit_cfe_frame_t;

	typedef struct packed {
		logic [31:0]      rem;
		logic [QUO_W-1:0] num_lo;
		logic [31:0]      span;
		logic [QUO_W-1:0] quo;
	} mit_cfe_lane_t;

	typedef struct packed {
		logic [10:0]                         id;
		mit_cfe_lane_t [NUM_LANES-1:0]       lane;
	} mit_cfe_work_t;

endpackage

>>> rtl/core/mit_cfe_front.sv
// Front stages: clamp each command value to its range (s1), then scale
// the offset by the code maximum and split it for the divider (s2).
// Depends on mit_cfe_pkg.
module mit_cfe_front (
	input  logic                          clk,
	input  logic                          en_s1,
	input  logic                          en_s2,
	input  mit_cfe_pkg::mit_cfe_cmd_t     cmd,
	input  mit_cfe_pkg::mit_cfe_limits_t  limits,
	output mit_cfe_pkg::mit_cfe_work_t    work
);

	typedef struct packed {
		logic [10:0]                                id;
		logic [mit_cfe_pkg::NUM_LANES-1:0][31:0]    offs;
		logic [mit_cfe_pkg::NUM_LANES-1:0][31:0]    span;
	} clamp_t;

	clamp_t                    clamp_c;
	clamp_t                    clamp_s1;
	mit_cfe_pkg::mit_cfe_work_t work_c;
	mit_cfe_pkg::mit_cfe_work_t work_s2;

	logic signed [32:0] val_c  [mit_cfe_pkg::NUM_LANES];
	logic signed [32:0] lim_c  [mit_cfe_pkg::NUM_LANES];
	logic signed [32:0] lo_c   [mit_cfe_pkg::NUM_LANES];
	logic signed [32:0] clip_c [mit_cfe_pkg::NUM_LANES];
	logic signed [32:0] dist_c [mit_cfe_pkg::NUM_LANES];
	logic signed [32:0] span_c [mit_cfe_pkg::NUM_LANES];
	logic        [47:0] num_c  [mit_cfe_pkg::NUM_LANES];

	always_comb begin
		val_c[mit_cfe_pkg::LANE_POS] = {cmd.cmd_position[31], cmd.cmd_position};
		val_c[mit_cfe_pkg::LANE_VEL] = {cmd.cmd_velocity[31], cmd.cmd_velocity};
		val_c[mit_cfe_pkg::LANE_KP]  = {cmd.gain_stiff[31], cmd.gain_stiff};
		val_c[mit_cfe_pkg::LANE_KD]  = {cmd.gain_damp[31], cmd.gain_damp};
		val_c[mit_cfe_pkg::LANE_TQ]  = {cmd.cmd_torque[31], cmd.cmd_torque};
		clamp_c.id = cmd.target_id;
		for (int k = 0; k < mit_cfe_pkg::NUM_LANES; k++) begin
			lim_c[k] = {2'b00, limits[k]};
			lo_c[k]  = mit_cfe_pkg::LANE_SYM[k] ? -lim_c[k] : 33'sd0;
			if (val_c[k] < lo_c[k]) begin
				clip_c[k] = lo_c[k];
			end else if (val_c[k] > lim_c[k]) begin
				clip_c[k] = lim_c[k];
			end else begin
				clip_c[k] = val_c[k];
			end
			dist_c[k] = clip_c[k] - lo_c[k];
			span_c[k] = lim_c[k] - lo_c[k];
			clamp_c.offs[k] = dist_c[k][31:0];
			clamp_c.span[k] = span_c[k][31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			clamp_s1 <= clamp_c;
		end
	end

	// offset * (2^b - 1) as (offset << b) - offset
	always_comb begin
		work_c.id = clamp_s1.id;
		for (int k = 0; k < mit_cfe_pkg::NUM_LANES; k++) begin
			if (mit_cfe_pkg::LANE_WIDE[k]) begin
				num_c[k] = {clamp_s1.offs[k], 16'd0} - {16'd0, clamp_s1.offs[k]};
			end else begin
				num_c[k] = {4'd0, clamp_s1.offs[k], 12'd0} - {16'd0, clamp_s1.offs[k]};
			end
			work_c.lane[k].rem    = num_c[k][47:16];
			work_c.lane[k].num_lo = num_c[k][15:0];
			work_c.lane[k].span   = clamp_s1.span[k];
			work_c.lane[k].quo    = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			work_s2 <= work_c;
		end
	end

	assign work = work_s2;

endmodule

>>> rtl/core/mit_cfe_div_stage.sv
// One restoring-division step for all five lanes: shift in one numerator
// bit, compare with the span, subtract on a hit. Depends on mit_cfe_pkg.
module mit_cfe_div_stage (
	input  logic                        clk,
	input  logic                        en,
	input  mit_cfe_pkg::mit_cfe_work_t  work_in,
	output mit_cfe_pkg::mit_cfe_work_t  work_out
);

	mit_cfe_pkg::mit_cfe_work_t work_c;
	mit_cfe_pkg::mit_cfe_work_t work_sn;

	logic [32:0] trial_c [mit_cfe_pkg::NUM_LANES];
	logic [32:0] diff_c  [mit_cfe_pkg::NUM_LANES];
	logic        hit_c   [mit_cfe_pkg::NUM_LANES];

	always_comb begin
		work_c.id = work_in.id;
		for (int k = 0; k < mit_cfe_pkg::NUM_LANES; k++) begin
			trial_c[k] = {work_in.lane[k].rem, work_in.lane[k].num_lo[mit_cfe_pkg::QUO_W-1]};
			diff_c[k]  = trial_c[k] - {1'b0, work_in.lane[k].span};
			hit_c[k]   = (work_in.lane[k].span != '0) &&
				(trial_c[k] >= {1'b0, work_in.lane[k].span});
			work_c.lane[k].rem    = hit_c[k] ? diff_c[k][31:0] : trial_c[k][31:0];
			work_c.lane[k].num_lo = {work_in.lane[k].num_lo[mit_cfe_pkg::QUO_W-2:0], 1'b0};
			work_c.lane[k].span   = work_in.lane[k].span;
			work_c.lane[k].quo    = {work_in.lane[k].quo[mit_cfe_pkg::QUO_W-2:0], hit_c[k]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			work_sn <= work_c;
		end
	end

	assign work_out = work_sn;

endmodule

>>> rtl/core/mit_command_frame_encoder.sv
// Top level of the command frame encoder: config registers, pipeline
// control, divider chain and frame packing.
// Depends on mit_cfe_pkg, mit_cfe_front, mit_cfe_div_stage, the assert header.
//
// Use: a command beat on in_valid/in_ready (in_data) yields exactly one
// frame beat on out_valid/out_ready (out_data): frame_id is the target id,
// payload holds the position, velocity, stiffness, damping and torque codes
// packed big-endian. Limits are written on cfg_valid/cfg_ready with
// cfg_index 0..4 (position, velocity, torque, stiffness, damping); other
// indexes are dropped. cfg_ready is always high.
// Pipeline: 19 register stages from input beat to output valid
// (clamp, scale, sixteen one-bit division steps for all five fields, frame).
// Throughput: one command per cycle while the receiver accepts frames; the sixteen
// divider steps are unrolled into stages so each command takes one step per stage.
// Reset clears all valid bits and loads the default limits.
// Receiver stall: the frame holds; stages behind it keep filling empty
// slots, and in_ready falls only once stage one is occupied and blocked.
`include "mit_command_frame_encoder_assert.svh"
module mit_command_frame_encoder (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      in_valid,
	output logic                                      in_ready,
	input  mit_cfe_pkg::mit_cfe_cmd_t                 in_data,
	output logic                                      out_valid,
	input  logic                                      out_ready,
	output mit_cfe_pkg::mit_cfe_frame_t               out_data,
	input  logic                                      cfg_valid,
	output logic                                      cfg_ready,
	input  logic [mit_cfe_pkg::REG_IDX_W-1:0]         cfg_index,
	input  logic [mit_cfe_pkg::LIMIT_W-1:0]           cfg_data
);

	localparam int FIRST_DIV = 2;
	localparam int LAST_DIV  = FIRST_DIV + mit_cfe_pkg::DIV_STEPS;
	localparam int STAGES    = LAST_DIV + 1;

	mit_cfe_pkg::mit_cfe_limits_t limits_q;
	logic [STAGES:1]              vld_s;
	logic [STAGES:1]              en;
	logic                         adv;
	mit_cfe_pkg::mit_cfe_work_t   div_s [LAST_DIV:FIRST_DIV];
	mit_cfe_pkg::mit_cfe_frame_t  frame_s19;
	mit_cfe_pkg::mit_cfe_frame_t  frame_c;
	mit_cfe_pkg::mit_cfe_lane_t   pos_last;
	mit_cfe_pkg::mit_cfe_lane_t   vel_last;
	logic                         pos_div_live;
	logic                         pos_rem_low;
	logic                         vel_span_zero;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q <= mit_cfe_pkg::LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				mit_cfe_pkg::REG_POSITION:  limits_q[mit_cfe_pkg::LANE_POS] <= cfg_data;
				mit_cfe_pkg::REG_VELOCITY:  limits_q[mit_cfe_pkg::LANE_VEL] <= cfg_data;
				mit_cfe_pkg::REG_TORQUE:    limits_q[mit_cfe_pkg::LANE_TQ]  <= cfg_data;
				mit_cfe_pkg::REG_STIFFNESS: limits_q[mit_cfe_pkg::LANE_KP]  <= cfg_data;
				mit_cfe_pkg::REG_DAMPING:   limits_q[mit_cfe_pkg::LANE_KD]  <= cfg_data;
				default: ;
			endcase
		end
	end

	// advance everything on a free output; otherwise fill empty stages only
	assign adv = !vld_s[STAGES] || out_ready;

	always_comb begin
		for (int i = 1; i <= STAGES; i++) begin
			en[i] = adv || !vld_s[i];
		end
	end

	assign in_ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s[1] <= en[1] ? in_valid : (vld_s[1] && !en[2]);
			for (int i = 2; i < STAGES; i++) begin
				vld_s[i] <= en[i] ? vld_s[i-1] : (vld_s[i] && !en[i+1]);
			end
			vld_s[STAGES] <= en[STAGES] ? vld_s[STAGES-1] : vld_s[STAGES];
		end
	end

	mit_cfe_front u_front (
		.clk    (clk),
		.en_s1  (en[1]),
		.en_s2  (en[2]),
		.cmd    (in_data),
		.limits (limits_q),
		.work   (div_s[FIRST_DIV])
	);

	for (genvar g = FIRST_DIV; g < LAST_DIV; g++) begin : g_div
		mit_cfe_div_stage u_div (
			.clk      (clk),
			.en       (en[g+1]),
			.work_in  (div_s[g]),
			.work_out (div_s[g+1])
		);
	end

	always_comb begin
		frame_c.frame_id = div_s[LAST_DIV].id;
		frame_c.payload  = {
			div_s[LAST_DIV].lane[mit_cfe_pkg::LANE_POS].quo[mit_cfe_pkg::POS_BITS-1:0],
			div_s[LAST_DIV].lane[mit_cfe_pkg::LANE_VEL].quo[mit_cfe_pkg::CODE_BITS-1:0],
			div_s[LAST_DIV].lane[mit_cfe_pkg::LANE_KP].quo[mit_cfe_pkg::CODE_BITS-1:0],
			div_s[LAST_DIV].lane[mit_cfe_pkg::LANE_KD].quo[mit_cfe_pkg::CODE_BITS-1:0],
			div_s[LAST_DIV].lane[mit_cfe_pkg::LANE_TQ].quo[mit_cfe_pkg::CODE_BITS-1:0]
		};
	end

	always_ff @(posedge clk) begin
		if (en[STAGES]) begin
			frame_s19 <= frame_c;
		end
	end

	assign out_valid = vld_s[STAGES];
	assign out_data  = frame_s19;

	assign pos_last      = div_s[LAST_DIV].lane[mit_cfe_pkg::LANE_POS];
	assign vel_last      = div_s[LAST_DIV].lane[mit_cfe_pkg::LANE_VEL];
	assign pos_div_live  = vld_s[LAST_DIV] && (pos_last.span != '0);
	assign pos_rem_low   = pos_last.rem < pos_last.span;
	assign vel_span_zero = vld_s[LAST_DIV] && (vel_last.span == '0);

	`MIT_CFE_ASSERT_NOW(a_ready_on_drain, out_ready, in_ready, "stall while output drains")
	`MIT_CFE_ASSERT_NOW(a_ready_on_empty, !vld_s[1], in_ready, "empty first stage not ready")
	`MIT_CFE_ASSERT_NEXT(a_last_moves, vld_s[LAST_DIV] && out_ready, out_valid, "beat lost")
	`MIT_CFE_ASSERT_NOW(a_rem_bound, pos_div_live, pos_rem_low, "remainder not below span")
	`MIT_CFE_ASSERT_NOW(a_zero_span, vel_span_zero, vel_last.quo == '0, "code on empty range")

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for mit_command_frame_encoder: drives motor commands and
// limit writes, predicts each packed CAN frame and compares it on the way out.
// Depends on mit_cfe_pkg and the encoder RTL.
module tb;

	localparam logic [mit_cfe_pkg::LIMIT_W-1:0] POS_LIM_RST = 31'd819200;
	localparam logic [mit_cfe_pkg::LIMIT_W-1:0] VEL_LIM_RST = 31'd1966080;
	localparam logic [mit_cfe_pkg::LIMIT_W-1:0] TQ_LIM_RST  = 31'd655360;
	localparam logic [mit_cfe_pkg::LIMIT_W-1:0] KP_LIM_RST  = 31'd32768000;
	localparam logic [mit_cfe_pkg::LIMIT_W-1:0] KD_LIM_RST  = 31'd327680;
	localparam logic [mit_cfe_pkg::LIMIT_W-1:0] LIM_MAX     = 31'h7FFFFFFF;
	localparam logic [mit_cfe_pkg::REG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int unsigned HOLD_CYCLES = 300;

	typedef enum logic [1:0] {RX_FREE, RX_BUSY, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	class frame_scoreboard;
		logic [mit_cfe_pkg::LIMIT_W-1:0] lim_pos, lim_vel, lim_tq, lim_kp, lim_kd;
		mit_cfe_pkg::mit_cfe_frame_t expected_q[$];
		int unsigned failures;

		function new();
			lim_pos = POS_LIM_RST;
			lim_vel = VEL_LIM_RST;
			lim_tq = TQ_LIM_RST;
			lim_kp = KP_LIM_RST;
			lim_kd = KD_LIM_RST;
			failures = 0;
		endfunction

		function void set_limit(logic [mit_cfe_pkg::REG_IDX_W-1:0] idx,
				logic [mit_cfe_pkg::LIMIT_W-1:0] val);
			case (idx)
				mit_cfe_pkg::REG_POSITION:  lim_pos = val;
				mit_cfe_pkg::REG_VELOCITY:  lim_vel = val;
				mit_cfe_pkg::REG_TORQUE:    lim_tq = val;
				mit_cfe_pkg::REG_STIFFNESS: lim_kp = val;
				mit_cfe_pkg::REG_DAMPING:   lim_kd = val;
				default: ;
			endcase
		endfunction

		// clamp to [lo, hi] and scale onto 0 .. 2^bits-1, rounding down
		function logic [15:0] quantize(logic signed [31:0] v, longint lo, longint hi,
				int unsigned bits);
			longint c;
			longint unsigned top, span, off;
			top = (64'd1 << bits) - 64'd1;
			c = v;
			if (c < lo) c = lo;
			if (c > hi) c = hi;
			span = hi - lo;
			if (span == 0) return 16'd0;
			off = c - lo;
			return 16'((off * top / span) & top);
		endfunction

		function longint sym_lo(logic [mit_cfe_pkg::LIMIT_W-1:0] lim);
			longint l;
			l = lim;
			return -l;
		endfunction

		function mit_cfe_pkg::mit_cfe_frame_t encode(mit_cfe_pkg::mit_cfe_cmd_t c);
			mit_cfe_pkg::mit_cfe_frame_t f;
			logic [15:0] pos;
			logic [11:0] vel, kp, kd, tq;
			pos = quantize(c.cmd_position, sym_lo(lim_pos), longint'(lim_pos),
				mit_cfe_pkg::POS_BITS);
			vel = 12'(quantize(c.cmd_velocity, sym_lo(lim_vel), longint'(lim_vel),
				mit_cfe_pkg::CODE_BITS));
			kp = 12'(quantize(c.gain_stiff, 0, longint'(lim_kp), mit_cfe_pkg::CODE_BITS));
			kd = 12'(quantize(c.gain_damp, 0, longint'(lim_kd), mit_cfe_pkg::CODE_BITS));
			tq = 12'(quantize(c.cmd_torque, sym_lo(lim_tq), longint'(lim_tq),
				mit_cfe_pkg::CODE_BITS));
			f.frame_id = c.target_id;
			f.payload = {pos, vel, kp, kd, tq};
			return f;
		endfunction

		function void note_cmd(mit_cfe_pkg::mit_cfe_cmd_t c);
			expected_q.push_back(encode(c));
		endfunction

		function void flag(string what, logic [63:0] exp_v, logic [63:0] got_v);
			failures++;
			if (failures <= 10)
				$display("%0t mismatch %s: expected %h got %h", $realtime, what, exp_v, got_v);
		endfunction

		function void check_frame(mit_cfe_pkg::mit_cfe_frame_t got);
			mit_cfe_pkg::mit_cfe_frame_t want;
			if (expected_q.size() == 0) begin
				flag("unexpected frame", 64'd0, got.payload);
				return;
			end
			want = expected_q.pop_front();
			if (got.frame_id !== want.frame_id)
				flag("frame_id", 64'(want.frame_id), 64'(got.frame_id));
			if (got.payload !== want.payload)
				flag("payload", want.payload, got.payload);
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	mit_cfe_pkg::mit_cfe_cmd_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	mit_cfe_pkg::mit_cfe_frame_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [mit_cfe_pkg::REG_IDX_W-1:0] cfg_index = '0;
	logic [mit_cfe_pkg::LIMIT_W-1:0] cfg_data = '0;
	bit hold_rx = 1'b0;

	frame_scoreboard sb = new();

	mit_command_frame_encoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	initial begin
		#5_000_000;
		$display("tb NOT OK");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_frame(out_data);
	end

	// receiver: switches between randomly chosen stall patterns, long hold on request
	initial begin
		int unsigned cyc;
		rx_mode_t mode;
		cyc = 0;
		mode = RX_FREE;
		forever begin
			@(posedge clk);
			if (hold_rx) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rx = 1'b0;
			end
			if (cyc % 64 == 0)
				mode = rx_mode_t'($urandom_range(0, 3));
			cyc++;
			case (mode)
				RX_FREE:     out_ready <= 1'b1;
				RX_BUSY:     out_ready <= ($urandom_range(0, 3) != 0);
				RX_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
				RX_PERIODIC: out_ready <= ((cyc % 7) < 3);
			endcase
		end
	end

	function automatic mit_cfe_pkg::mit_cfe_cmd_t mk_cmd(logic [10:0] id, logic [31:0] p,
			logic [31:0] v, logic [31:0] kp, logic [31:0] kd, logic [31:0] t);
		mit_cfe_pkg::mit_cfe_cmd_t c;
		c.target_id = id;
		c.cmd_position = p;
		c.cmd_velocity = v;
		c.gain_stiff = kp;
		c.gain_damp = kd;
		c.cmd_torque = t;
		return c;
	endfunction

	// value in [lo, hi], wrapped to 32 bits
	function automatic logic [31:0] rand_between(longint lo, longint hi);
		longint unsigned span, r;
		span = hi - lo;
		r = {$urandom, $urandom};
		return 32'(lo + longint'(r % (span + 1)));
	endfunction

	function automatic logic [31:0] rand_sym(logic [mit_cfe_pkg::LIMIT_W-1:0] lim);
		longint l;
		l = lim;
		case ($urandom_range(0, 9))
			0, 1: return $urandom;
			2: return 32'(l + $urandom_range(0, 2) - 1);
			3: return 32'(-l + $urandom_range(0, 2) - 1);
			4: return 32'($urandom_range(0, 2) - 1);
			default: return rand_between(-l - l / 4, l + l / 4);
		endcase
	endfunction

	function automatic logic [31:0] rand_gain(logic [mit_cfe_pkg::LIMIT_W-1:0] lim);
		longint l;
		l = lim;
		case ($urandom_range(0, 9))
			0, 1: return $urandom;
			2: return 32'(l + $urandom_range(0, 2) - 1);
			3: return 32'($urandom_range(0, 2) - 1);
			default: return rand_between(-l / 4, l + l / 4);
		endcase
	endfunction

	function automatic mit_cfe_pkg::mit_cfe_cmd_t rand_cmd();
		return mk_cmd(11'($urandom_range(0, 2047)), rand_sym(sb.lim_pos),
			rand_sym(sb.lim_vel), rand_gain(sb.lim_kp), rand_gain(sb.lim_kd),
			rand_sym(sb.lim_tq));
	endfunction

	function automatic logic [mit_cfe_pkg::LIMIT_W-1:0] rand_limit();
		case ($urandom_range(0, 2))
			0: return 31'($urandom_range(1, 4096));
			1: return 31'($urandom_range(4096, 32'h0100_0000));
			default: return 31'($urandom_range(32'h0100_0000, 32'h7FFF_FFFF));
		endcase
	endfunction

	task automatic send_cmd(input mit_cfe_pkg::mit_cfe_cmd_t c);
		in_data <= c;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		sb.note_cmd(c);
	endtask

	task automatic write_limit(input logic [mit_cfe_pkg::REG_IDX_W-1:0] idx,
			input logic [mit_cfe_pkg::LIMIT_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.set_limit(idx, val);
	endtask

	task automatic apply_limits(input logic [mit_cfe_pkg::LIMIT_W-1:0] pos,
			input logic [mit_cfe_pkg::LIMIT_W-1:0] vel,
			input logic [mit_cfe_pkg::LIMIT_W-1:0] tq,
			input logic [mit_cfe_pkg::LIMIT_W-1:0] kp,
			input logic [mit_cfe_pkg::LIMIT_W-1:0] kd);
		write_limit(mit_cfe_pkg::REG_POSITION, pos);
		write_limit(mit_cfe_pkg::REG_VELOCITY, vel);
		write_limit(mit_cfe_pkg::REG_TORQUE, tq);
		write_limit(mit_cfe_pkg::REG_STIFFNESS, kp);
		write_limit(mit_cfe_pkg::REG_DAMPING, kd);
		cfg_valid <= 1'b0;
	endtask

	// drop valid and wait for the pipeline to drain
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_random(input int unsigned n);
		int unsigned left, burst, gap;
		left = n;
		while (left > 0) begin
			burst = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			for (int i = 0; i < burst && left > 0; i++) begin
				send_cmd(rand_cmd());
				left--;
			end
			if (gap != 0 && left > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset limits: extremes, range ends and their neighbors
		send_cmd(mk_cmd(11'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0));
		send_cmd(mk_cmd(11'h7FF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h7FFFFFFF));
		send_cmd(mk_cmd(11'h555, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h80000000));
		send_cmd(mk_cmd(11'h2AA, 32'd819200, 32'd1966080, 32'd32768000, 32'd327680,
			32'd655360));
		send_cmd(mk_cmd(11'h0F0, -32'sd819200, -32'sd1966080, 32'd0, 32'd0, -32'sd655360));
		send_cmd(mk_cmd(11'h10F, 32'd819201, 32'd1966081, 32'd32768001, 32'd327681,
			32'd655361));
		send_cmd(mk_cmd(11'h3C3, -32'sd819201, -32'sd1966081, -32'sd1, -32'sd1,
			-32'sd655361));
		send_cmd(mk_cmd(11'h43C, 32'd819199, 32'd1966079, 32'd32767999, 32'd327679,
			32'd655359));
		send_cmd(mk_cmd(11'h123, 32'd409600, -32'sd983040, 32'd16384000, 32'd163840,
			-32'sd327680));
		send_cmd(mk_cmd(11'h456, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1));
		send_cmd(mk_cmd(11'h789, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1));
		settle();

		// zero limits collapse every range to a point
		apply_limits('0, '0, '0, '0, '0);
		send_cmd(mk_cmd(11'h001, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0));
		send_cmd(mk_cmd(11'h002, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h7FFFFFFF));
		send_cmd(mk_cmd(11'h004, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h80000000));
		settle();

		apply_limits(LIM_MAX, LIM_MAX, LIM_MAX, LIM_MAX, LIM_MAX);
		send_cmd(mk_cmd(11'h7FE, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h7FFFFFFF));
		send_cmd(mk_cmd(11'h7FD, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h80000000));
		send_cmd(mk_cmd(11'h7FB, 32'h80000001, 32'h80000001, 32'h3FFFFFFF, 32'h40000000,
			32'h80000001));
		send_cmd(mk_cmd(11'h7F7, -32'sd1, 32'd0, 32'd1, -32'sd1, 32'd1));
		settle();

		// random phases; the first one holds the receiver off to fill the pipe
		apply_limits(POS_LIM_RST, VEL_LIM_RST, TQ_LIM_RST, KP_LIM_RST, KD_LIM_RST);
		hold_rx = 1'b1;
		send_random(150);
		settle();

		send_random(100);
		settle();

		apply_limits(31'd1, 31'd1, 31'd1, 31'd1, 31'd1);
		send_random(100);
		settle();

		apply_limits(31'($urandom_range(1, 4096)), 31'($urandom_range(1, 4096)),
			31'($urandom_range(1, 4096)), 31'($urandom_range(1, 4096)),
			31'($urandom_range(1, 4096)));
		send_random(150);
		settle();

		apply_limits(rand_limit(), rand_limit(), rand_limit(), rand_limit(), rand_limit());
		send_random(150);
		settle();

		apply_limits(rand_limit(), '0, rand_limit(), '0, rand_limit());
		write_limit(REG_UNUSED, 31'($urandom));
		cfg_valid <= 1'b0;
		send_random(100);
		settle();

		apply_limits(LIM_MAX, rand_limit(), 31'd1, rand_limit(), LIM_MAX);
		send_random(50);
		settle();

		repeat (40) @(posedge clk);
		if (sb.failures == 0 && sb.pending() == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end
endmodule
